### rtl/core/phc_pkg.sv
// power histogram calibrator: shared constants, field widths and helpers
// no dependencies; used by the channel interfaces and the top level
package phc_pkg;

   // default geometry
   localparam int PHC_BINS        = 256;
   localparam int PHC_COUNT_WIDTH = 32;

   // bin i stands for power i - BIN_OFFSET half-dBm
   localparam int BIN_OFFSET  = 300;
   localparam int MEAN_OFFSET = BIN_OFFSET * 256;
   // highest bin taking part in the mode search (-60 dBm)
   localparam int MODE_LIMIT  = 180;
   localparam int MODEL_BIAS  = 28;

   // payload widths
   localparam int POWER_W  = 10;
   localparam int MEAN_W   = 18;
   localparam int RMAX_W   = 10;
   localparam int MODEL_W  = 11;
   localparam int NOISE_W  = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // request function codes
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_OFS = 2'd2;

   // configuration reset values
   localparam logic [CSR_DATA_W-1:0] MAX_COUNT_RST = 32'd10000000;
   localparam logic [CSR_DATA_W-1:0] MIN_COUNT_RST = 32'd100;
   localparam logic [NOISE_W-1:0]    NOISE_OFS_RST = 9'd0;

   // 10 div n for n in 0..10 (zero when n is zero)
   function automatic logic [3:0] ten_div(input logic [3:0] n);
      logic [3:0] q;
      case (n)
         4'd1:    q = 4'd10;
         4'd2:    q = 4'd5;
         4'd3:    q = 4'd3;
         4'd4:    q = 4'd2;
         4'd5:    q = 4'd2;
         4'd6:    q = 4'd1;
         4'd7:    q = 4'd1;
         4'd8:    q = 4'd1;
         4'd9:    q = 4'd1;
         4'd10:   q = 4'd1;
         default: q = 4'd0;
      endcase
      return q;
   endfunction

endpackage

### rtl/core/phc_if.sv
// power histogram calibrator: request, response and register write channels
// depends on phc_pkg for the payload widths
interface phc_req_if import phc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic signed [POWER_W-1:0] power_half_db;

   modport source (output valid, func, power_half_db, input ready);
   modport sink   (input valid, func, power_half_db, output ready);
endinterface

interface phc_rsp_if import phc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [MEAN_W-1:0]  real_mean_q8;
   logic signed [RMAX_W-1:0]  real_max;
   logic signed [MODEL_W-1:0] model_mean;
   logic signed [MODEL_W-1:0] model_max;
   logic                      halved;

   modport source (output valid, real_mean_q8, real_max, model_mean, model_max, halved,
                   input ready);
   modport sink   (input valid, real_mean_q8, real_max, model_mean, model_max, halved,
                   output ready);
endinterface

interface phc_csr_if import phc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/phc_ram.sv
// power histogram calibrator: generic single write, single read ram
// registered read data; no dependencies
module phc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/power_histogram_calibrator_top.sv
// power histogram calibrator top level: histogram store, sequencer, sweep and divider
// depends on phc_pkg, the phc channel interfaces and phc_ram
//
//   channel  dir  transaction
//   req_ch   in   func, power_half_db: add one sample or clear
//   rsp_ch   out  real_mean_q8, real_max, model_mean, model_max, halved
//   csr_ch   in   index, data: register write, always ready
//
// a sample takes one histogram ram read, then one read-modify-write.
// a statistics transaction adds a ram sweep (with halving write-back), a
// one-bit-per-cycle division, and the load of the output register, which
// waits while that register is still full. a clear zeroes every bin; after
// reset a clearing pass runs before the first request is taken. an rsp_ch
// stall holds the output register, and a new result waits until it drains.
module power_histogram_calibrator_top import phc_pkg::*; #(
   parameter int BINS        = PHC_BINS,
   parameter int COUNT_WIDTH = PHC_COUNT_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   phc_req_if.sink   req_ch,
   phc_rsp_if.source rsp_ch,
   phc_csr_if.sink   csr_ch
);

   localparam int CW     = COUNT_WIDTH;
   localparam int BIN_W  = $clog2(BINS);
   localparam int WSW    = CW + 2 * BIN_W;
   localparam int DW     = WSW + 8;
   localparam int STEP_W = $clog2(DW);
   localparam int CMP_W  = (CW > CSR_DATA_W) ? CW : CSR_DATA_W;
   localparam int MODE_LIM = (MODE_LIMIT > BINS - 1) ? BINS - 1 : MODE_LIMIT;

   localparam logic signed [11:0] BIN_LAST = 12'(BINS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_SWEEP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0]     max_cnt_ff, max_cnt_in;
   logic [CSR_DATA_W-1:0]     min_cnt_ff, min_cnt_in;
   logic signed [NOISE_W-1:0] noise_ff, noise_in;

   logic [CW-1:0]   total_ff, total_in;
   logic [CW+3:0]   last_x10_ff, last_x10_in;
   logic [BIN_W:0]  addr_ff, addr_in;
   logic [BIN_W-1:0] idx_ff, idx_in;
   logic            halve_ff, halve_in;

   logic             rd_vld_ff, rd_vld_in;
   logic [BIN_W-1:0] rd_idx_ff, rd_idx_in;
   logic             prod_vld_ff, prod_vld_in;
   logic [WSW-1:0]   prod_ff, prod_in;
   logic [WSW-1:0]   wsum_ff, wsum_in;
   logic [BIN_W-1:0] top_ff, top_in;
   logic [BIN_W-1:0] mode_ff, mode_in;
   logic [CW-1:0]    mode_val_ff, mode_val_in;
   logic [CW-1:0]    n_ff, n_in;

   logic [DW-1:0]     dvd_ff, dvd_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [MEAN_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [MEAN_W-1:0]  rsp_mean_ff, rsp_mean_in;
   logic signed [RMAX_W-1:0]  rsp_rmax_ff, rsp_rmax_in;
   logic signed [MODEL_W-1:0] rsp_mmean_ff, rsp_mmean_in;
   logic signed [MODEL_W-1:0] rsp_mmax_ff, rsp_mmax_in;
   logic                      rsp_halved_ff, rsp_halved_in;

   // histogram ram port signals
   logic             ram_wr_en;
   logic [BIN_W-1:0] ram_wr_addr;
   logic [CW-1:0]    ram_wr_data;
   logic             ram_rd_en;
   logic [BIN_W-1:0] ram_rd_addr;
   logic [CW-1:0]    ram_rd_data;

   // combinational helpers
   logic signed [11:0] bin_raw;
   logic [BIN_W-1:0]   bin_idx;
   logic [CW-1:0]      tot_inc;
   logic [CW:0]        rem_sh;
   logic               rem_ge;
   logic [MEAN_W-1:0]  mean_base;
   logic [3:0]         ten_q;
   logic signed [12:0] mmean_w;
   logic signed [12:0] mmax_w;
   logic signed [12:0] rmax_w;

   phc_ram #(
      .WIDTH (CW),
      .DEPTH (BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.real_mean_q8 = rsp_mean_ff;
   assign rsp_ch.real_max     = rsp_rmax_ff;
   assign rsp_ch.model_mean   = rsp_mmean_ff;
   assign rsp_ch.model_max    = rsp_mmax_ff;
   assign rsp_ch.halved       = rsp_halved_ff;

   // bin index with saturation at both ends
   always_comb begin
      bin_raw = 12'(req_ch.power_half_db) + 12'sd300;
      if (bin_raw < 12'sd0) begin
         bin_idx = '0;
      end else if (bin_raw > BIN_LAST) begin
         bin_idx = BIN_W'(BINS - 1);
      end else begin
         bin_idx = bin_raw[BIN_W-1:0];
      end
   end

   assign tot_inc = total_ff + CW'(1);

   // restoring division step
   assign rem_sh = {rem_ff, dvd_ff[DW-1]};
   assign rem_ge = (rem_sh >= {1'b0, n_ff});

   // result fields
   always_comb begin
      mean_base = (n_ff == '0) ? '0 : quo_ff;
      ten_q     = ten_div((n_ff <= CW'(10)) ? n_ff[3:0] : 4'd0);
      mmean_w   = $signed(13'(mode_ff)) - 13'sd300 - 13'(noise_ff);
      mmax_w    = mmean_w + $signed({8'd0, ten_q, 1'b0}) + 13'(MODEL_BIAS);
      rmax_w    = $signed(13'(top_ff)) - 13'sd300;
   end

   always_comb begin
      state_in    = state_ff;
      max_cnt_in  = max_cnt_ff;
      min_cnt_in  = min_cnt_ff;
      noise_in    = noise_ff;
      total_in    = total_ff;
      last_x10_in = last_x10_ff;
      addr_in     = addr_ff;
      idx_in      = idx_ff;
      halve_in    = halve_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      prod_vld_in = 1'b0;
      prod_in     = prod_ff;
      wsum_in     = wsum_ff;
      top_in      = top_ff;
      mode_in     = mode_ff;
      mode_val_in = mode_val_ff;
      n_in        = n_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_rmax_in   = rsp_rmax_ff;
      rsp_mmean_in  = rsp_mmean_ff;
      rsp_mmax_in   = rsp_mmax_ff;
      rsp_halved_in = rsp_halved_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = bin_idx;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MAX_COUNT: max_cnt_in = csr_ch.data;
            CSR_MIN_COUNT: min_cnt_in = csr_ch.data;
            CSR_NOISE_OFS: noise_in   = csr_ch.data[NOISE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff[BIN_W-1:0];
            ram_wr_data = '0;
            total_in    = '0;
            last_x10_in = '0;
            addr_in     = addr_ff + (BIN_W + 1)'(1);
            if (addr_ff == (BIN_W + 1)'(BINS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.func == FUNC_CLEAR) begin
                  addr_in  = '0;
                  state_in = ST_CLEAR;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = bin_idx;
                  idx_in      = bin_idx;
                  state_in    = ST_UPDATE;
               end
            end
         end

         ST_UPDATE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data + CW'(1);
            total_in    = tot_inc;
            n_in        = tot_inc;
            addr_in     = '0;
            wsum_in     = '0;
            top_in      = '0;
            mode_in     = '0;
            mode_val_in = '0;
            if (CMP_W'(tot_inc) >= CMP_W'(max_cnt_ff)) begin
               halve_in = 1'b1;
               state_in = ST_SWEEP;
            end else if (((CW + 4)'(tot_inc) >= last_x10_ff) &&
                         (CMP_W'(tot_inc) >= CMP_W'(min_cnt_ff))) begin
               halve_in = 1'b0;
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SWEEP: begin
            // read bin addr, process bin addr-1, accumulate bin addr-2
            if (addr_ff != (BIN_W + 1)'(BINS)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = addr_ff[BIN_W-1:0];
               rd_vld_in   = 1'b1;
               rd_idx_in   = addr_ff[BIN_W-1:0];
               addr_in     = addr_ff + (BIN_W + 1)'(1);
            end
            if (rd_vld_ff) begin
               prod_vld_in = 1'b1;
               prod_in     = WSW'(rd_idx_ff) * WSW'(ram_rd_data);
               if (ram_rd_data != '0) begin
                  top_in = rd_idx_ff;
               end
               if ((rd_idx_ff <= BIN_W'(MODE_LIM)) && (ram_rd_data > mode_val_ff)) begin
                  mode_in     = rd_idx_ff;
                  mode_val_in = ram_rd_data;
               end
               if (halve_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = rd_idx_ff;
                  ram_wr_data = ram_rd_data >> 1;
               end
            end
            if (prod_vld_ff) begin
               wsum_in = wsum_ff + prod_ff;
            end
            if ((addr_ff == (BIN_W + 1)'(BINS)) && !rd_vld_ff && !prod_vld_ff) begin
               dvd_in   = {wsum_ff, 8'd0};
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end

         ST_DIVIDE: begin
            rem_in  = rem_ge ? CW'(rem_sh - {1'b0, n_ff}) : rem_sh[CW-1:0];
            quo_in  = {quo_ff[MEAN_W-2:0], rem_ge};
            dvd_in  = dvd_ff << 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DW - 1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = mean_base - MEAN_W'(MEAN_OFFSET);
               rsp_rmax_in   = rmax_w[RMAX_W-1:0];
               rsp_mmean_in  = mmean_w[MODEL_W-1:0];
               rsp_mmax_in   = mmax_w[MODEL_W-1:0];
               rsp_halved_in = halve_ff;
               if (halve_ff) begin
                  total_in = n_ff >> 1;
               end else begin
                  last_x10_in = ((CW + 4)'(n_ff) << 3) + ((CW + 4)'(n_ff) << 1);
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         max_cnt_ff   <= MAX_COUNT_RST;
         min_cnt_ff   <= MIN_COUNT_RST;
         noise_ff     <= NOISE_OFS_RST;
         total_ff     <= '0;
         last_x10_ff  <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_cnt_ff   <= max_cnt_in;
         min_cnt_ff   <= min_cnt_in;
         noise_ff     <= noise_in;
         total_ff     <= total_in;
         last_x10_ff  <= last_x10_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      halve_ff      <= halve_in;
      rd_idx_ff     <= rd_idx_in;
      prod_ff       <= prod_in;
      wsum_ff       <= wsum_in;
      top_ff        <= top_in;
      mode_ff       <= mode_in;
      mode_val_ff   <= mode_val_in;
      n_ff          <= n_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_rmax_ff   <= rsp_rmax_in;
      rsp_mmean_ff  <= rsp_mmean_in;
      rsp_mmax_ff   <= rsp_mmax_in;
      rsp_halved_ff <= rsp_halved_in;
   end

endmodule
